// ===== rtl/siie_pkg.sv =====
// Shared types, constants and opcodes for the small instruction executor.
`default_nettype none
package siie_pkg;

	localparam int MEM_BYTES = 256;
	localparam int NUM_REGS  = 16;
	localparam int PAD_BYTES = 4;
	localparam int BANKS     = 4;
	localparam int BANK_W    = $clog2(BANKS);
	localparam int ROWS      = (MEM_BYTES + PAD_BYTES) / BANKS;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int REG_W     = $clog2(NUM_REGS);

	localparam logic       REQ_LOAD  = 1'b0;
	localparam logic       REQ_EXEC  = 1'b1;
	localparam logic [4:0] IMM5_MASK = 5'h1F;

	typedef enum logic [7:0] {
		OP_MOVI  = 8'h00,
		OP_MOV   = 8'h01,
		OP_LOAD  = 8'h02,
		OP_STORE = 8'h03,
		OP_CMP   = 8'h04,
		OP_JMP   = 8'h05,
		OP_JG    = 8'h06,
		OP_JL    = 8'h07,
		OP_JE    = 8'h08,
		OP_ADD   = 8'h09,
		OP_SUB   = 8'h0A,
		OP_AND   = 8'h0B,
		OP_OR    = 8'h0C,
		OP_XOR   = 8'h0D,
		OP_SHL   = 8'h0E,
		OP_SAR   = 8'h0F
	} opcode_t;

	typedef enum logic [1:0] {
		DM_NONE,
		DM_BYTE,
		DM_WORD
	} dm_wmode_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  pc;
		logic [31:0] instr_word;
		logic [7:0]  load_addr;
		logic [7:0]  load_byte;
	} req_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic [31:0] written_value;
		logic        flag_equal;
		logic        flag_greater;
		logic        flag_less;
	} rsp_t;

	typedef struct packed {
		logic eq;
		logic gt;
		logic lt;
	} flags_t;

	typedef struct packed {
		dm_wmode_t   wmode;
		logic        rd_en;
		logic [7:0]  addr;
		logic [31:0] wdata;
	} dmem_req_t;

	typedef struct packed {
		logic [15:0]      next_pc;
		logic             halted;
		logic [31:0]      wv;
		logic             reg_we;
		logic [REG_W-1:0] reg_addr;
		logic             is_load;
		flags_t           flags;
		dmem_req_t        dm;
	} exec_t;

endpackage
`default_nettype wire

// ===== rtl/siie_regfile.sv =====
// Register file: sixteen words, two registered read ports, one write port.
`default_nettype none
module siie_regfile (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire logic [siie_pkg::REG_W-1:0]  rd_addr_x,
	input  wire logic [siie_pkg::REG_W-1:0]  rd_addr_y,
	input  wire logic                        wr_en,
	input  wire logic [siie_pkg::REG_W-1:0]  wr_addr,
	input  wire logic [31:0]                 wr_data,
	output logic      [31:0]                 rd_x_s1,
	output logic      [31:0]                 rd_y_s1
);

	logic [31:0]                   regs_q [siie_pkg::NUM_REGS];
	logic [siie_pkg::NUM_REGS-1:0] valid_q;
	logic [31:0]                   rd_x_d;
	logic [31:0]                   rd_y_d;

	// Write-through: a read in the same cycle as a write sees the new value.
	always_comb begin
		if (wr_en && wr_addr == rd_addr_x) begin
			rd_x_d = wr_data;
		end else if (valid_q[rd_addr_x]) begin
			rd_x_d = regs_q[rd_addr_x];
		end else begin
			rd_x_d = '0;
		end
		if (wr_en && wr_addr == rd_addr_y) begin
			rd_y_d = wr_data;
		end else if (valid_q[rd_addr_y]) begin
			rd_y_d = regs_q[rd_addr_y];
		end else begin
			rd_y_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_x_s1 <= rd_x_d;
			rd_y_s1 <= rd_y_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/siie_dmem.sv =====
// Data memory: four byte banks for unaligned word access, cleared after reset.
`default_nettype none
module siie_dmem (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire siie_pkg::dmem_req_t req,
	output logic      [31:0]         rdata,
	output logic                     busy
);

	logic [7:0]                  mem_q [siie_pkg::BANKS][siie_pkg::ROWS];
	logic [7:0]                  rd_q  [siie_pkg::BANKS];
	logic [siie_pkg::BANK_W-1:0] off_q;
	logic [siie_pkg::ROW_W-1:0]  clr_row_q;
	logic                        busy_q;

	logic [siie_pkg::BANKS-1:0]  bank_we;
	logic [siie_pkg::ROW_W-1:0]  bank_row [siie_pkg::BANKS];
	logic [7:0]                  bank_wd  [siie_pkg::BANKS];

	// Byte k of the word lives in bank (addr + k) mod 4; banks below the
	// start offset take the next row.
	always_comb begin
		for (int j = 0; j < siie_pkg::BANKS; j++) begin
			logic [siie_pkg::BANK_W-1:0] k;
			k = siie_pkg::BANK_W'(j) - req.addr[siie_pkg::BANK_W-1:0];
			bank_row[j] = siie_pkg::ROW_W'(req.addr[7:siie_pkg::BANK_W])
				+ siie_pkg::ROW_W'(siie_pkg::BANK_W'(j) < req.addr[siie_pkg::BANK_W-1:0]);
			bank_wd[j]  = req.wdata[8*k +: 8];
			bank_we[j]  = (req.wmode == siie_pkg::DM_WORD)
				|| (req.wmode == siie_pkg::DM_BYTE && k == '0);
			if (busy_q) begin
				bank_row[j] = clr_row_q;
				bank_wd[j]  = '0;
				bank_we[j]  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + siie_pkg::ROW_W'(1);
			if (clr_row_q == siie_pkg::ROW_W'(siie_pkg::ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < siie_pkg::BANKS; j++) begin
			if (bank_we[j]) begin
				mem_q[j][bank_row[j]] <= bank_wd[j];
			end
			if (req.rd_en) begin
				rd_q[j] <= mem_q[j][bank_row[j]];
			end
		end
		if (req.rd_en) begin
			off_q <= req.addr[siie_pkg::BANK_W-1:0];
		end
	end

	// Rotate bank outputs back into byte order.
	always_comb begin
		for (int k = 0; k < siie_pkg::BANKS; k++) begin
			rdata[8*k +: 8] = rd_q[off_q + siie_pkg::BANK_W'(k)];
		end
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== rtl/siie_alu.sv =====
// Instruction decode and execute: next pc, halt, register and memory effects.
`default_nettype none
module siie_alu (
	input  wire siie_pkg::req_t   item,
	input  wire logic [31:0]      op_x,
	input  wire logic [31:0]      op_y,
	input  wire siie_pkg::flags_t flags_cur,
	output siie_pkg::exec_t       res
);

	siie_pkg::opcode_t op;
	logic [15:0]       imm;
	logic [4:0]        imm5;
	logic [15:0]       seq;
	logic [15:0]       target;

	always_comb begin
		op     = siie_pkg::opcode_t'(item.instr_word[7:0]);
		imm    = item.instr_word[31:16];
		imm5   = item.instr_word[28:24] & siie_pkg::IMM5_MASK;
		seq    = {8'd0, item.pc} + 16'd4;
		target = seq + imm;

		res          = '0;
		res.next_pc  = seq;
		res.reg_addr = item.instr_word[15:12];
		res.flags    = flags_cur;
		res.dm.wmode = siie_pkg::DM_NONE;

		if (item.req_type == siie_pkg::REQ_LOAD) begin
			res.next_pc  = '0;
			res.dm.wmode = siie_pkg::DM_BYTE;
			res.dm.addr  = item.load_addr;
			res.dm.wdata = {24'd0, item.load_byte};
		end else begin
			case (op)
				siie_pkg::OP_MOVI: begin
					res.wv     = {{16{imm[15]}}, imm};
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_MOV: begin
					res.wv     = op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_LOAD: begin
					// value arrives from memory one stage later
					res.reg_we   = 1'b1;
					res.is_load  = 1'b1;
					res.dm.rd_en = 1'b1;
					res.dm.addr  = op_y[7:0];
				end
				siie_pkg::OP_STORE: begin
					res.wv       = op_y;
					res.dm.wmode = siie_pkg::DM_WORD;
					res.dm.addr  = op_x[7:0];
					res.dm.wdata = op_y;
				end
				siie_pkg::OP_CMP: begin
					res.flags.eq = (op_x == op_y);
					res.flags.gt = ($signed(op_x) > $signed(op_y));
					res.flags.lt = ($signed(op_x) < $signed(op_y));
				end
				siie_pkg::OP_JMP: res.next_pc = target;
				siie_pkg::OP_JG:  res.next_pc = flags_cur.gt ? target : seq;
				siie_pkg::OP_JL:  res.next_pc = flags_cur.lt ? target : seq;
				siie_pkg::OP_JE:  res.next_pc = flags_cur.eq ? target : seq;
				siie_pkg::OP_ADD: begin
					res.wv     = op_x + op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_SUB: begin
					res.wv     = op_x - op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_AND: begin
					res.wv     = op_x & op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_OR: begin
					res.wv     = op_x | op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_XOR: begin
					res.wv     = op_x ^ op_y;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_SHL: begin
					res.wv     = op_x << imm5;
					res.reg_we = 1'b1;
				end
				siie_pkg::OP_SAR: begin
					res.wv     = 32'($signed(op_x) >>> imm5);
					res.reg_we = 1'b1;
				end
				default: begin
					res.next_pc = {8'd0, item.pc};
					res.halted  = 1'b1;
				end
			endcase
			// halt unless the next word is aligned and fully inside memory
			if (!res.halted && (({1'b0, res.next_pc} + 17'd3 >= 17'(siie_pkg::MEM_BYTES))
				|| res.next_pc[1:0] != 2'd0)) begin
				res.halted = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/small_isa_instruction_executor_core.sv =====
// Stages: execute, then result, which drives rsp. Throughput: one transaction per cycle
// while rsp_stall is low, loads and back-to-back dependencies included
// (operands are forwarded from the result stage into the execute stage).
// Reset clears registers and flags at once; data memory is cleared by a pass over its
// 65 rows, one row of all four byte banks per cycle, while input stays stalled.
`default_nettype none
module small_isa_instruction_executor_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire siie_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output siie_pkg::rsp_t      rsp
);

	logic                 valid_s1;
	siie_pkg::req_t       item_s1;
	logic [31:0]          rd_x_s1;
	logic [31:0]          rd_y_s1;

	logic                 valid_s2;
	logic [15:0]          next_pc_s2;
	logic                 halted_s2;
	logic [31:0]          wv_s2;
	logic                 reg_we_s2;
	logic [siie_pkg::REG_W-1:0] reg_addr_s2;
	logic                 is_load_s2;
	siie_pkg::flags_t     flags_s2;

	siie_pkg::flags_t     flags_q;

	logic                 in_acc;
	logic                 out_acc;
	logic                 s2_load;
	logic                 adv_s1;
	logic                 dm_busy;
	logic [31:0]          dm_rdata;
	logic [31:0]          result_s2;
	logic [31:0]          op_x;
	logic [31:0]          op_y;
	siie_pkg::exec_t      exec;
	siie_pkg::dmem_req_t  dm_req;

	assign out_acc   = valid_s2 && !rsp_stall;
	assign s2_load   = !valid_s2 || !rsp_stall;
	assign adv_s1    = valid_s1 && s2_load;
	assign req_stall = dm_busy || (valid_s1 && !s2_load);
	assign in_acc    = req_valid && !req_stall;

	assign result_s2 = is_load_s2 ? dm_rdata : wv_s2;

	// The result stage holds the only older item whose register write is pending.
	always_comb begin
		op_x = rd_x_s1;
		op_y = rd_y_s1;
		if (valid_s2 && reg_we_s2 && reg_addr_s2 == item_s1.instr_word[15:12]) begin
			op_x = result_s2;
		end
		if (valid_s2 && reg_we_s2 && reg_addr_s2 == item_s1.instr_word[11:8]) begin
			op_y = result_s2;
		end
	end

	siie_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_acc),
		.rd_addr_x (req.instr_word[15:12]),
		.rd_addr_y (req.instr_word[11:8]),
		.wr_en     (out_acc && reg_we_s2),
		.wr_addr   (reg_addr_s2),
		.wr_data   (result_s2),
		.rd_x_s1   (rd_x_s1),
		.rd_y_s1   (rd_y_s1)
	);

	siie_alu u_alu (
		.item      (item_s1),
		.op_x      (op_x),
		.op_y      (op_y),
		.flags_cur (flags_q),
		.res       (exec)
	);

	// Memory side effects happen only when the item leaves the execute stage.
	always_comb begin
		dm_req = exec.dm;
		if (!adv_s1) begin
			dm_req.wmode = siie_pkg::DM_NONE;
			dm_req.rd_en = 1'b0;
		end
	end

	siie_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rdata  (dm_rdata),
		.busy   (dm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				flags_q <= exec.flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= req;
		end
		if (adv_s1) begin
			next_pc_s2  <= exec.next_pc;
			halted_s2   <= exec.halted;
			wv_s2       <= exec.wv;
			reg_we_s2   <= exec.reg_we;
			reg_addr_s2 <= exec.reg_addr;
			is_load_s2  <= exec.is_load;
			flags_s2    <= exec.flags;
		end
	end

	assign rsp_valid = valid_s2;

	always_comb begin
		rsp.next_pc       = next_pc_s2;
		rsp.halted        = halted_s2;
		rsp.written_value = result_s2;
		rsp.flag_equal    = flags_s2.eq;
		rsp.flag_greater  = flags_s2.gt;
		rsp.flag_less     = flags_s2.lt;
	end

endmodule
`default_nettype wire
